// ===== hw/rtl/bezier_pan_trajectory_defines.svh =====
// Assertion macros shared by the bezier pan trajectory RTL.
`ifndef BEZIER_PAN_TRAJECTORY_DEFINES_SVH
`define BEZIER_PAN_TRAJECTORY_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define BPT_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("bpt assertion failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define BPT_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("bpt assertion failed");

`endif

// ===== hw/rtl/bpt_pkg.sv =====
// Shared types and constants of the bezier pan trajectory block.
package bpt_pkg;

  localparam int unsigned EdgeOffsetDefault = 0;
  localparam logic [27:0] CntMax = 28'hFFFFFFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_TARGET_X = 3'd0;
  localparam logic [2:0] REG_TARGET_Y = 3'd1;
  localparam logic [2:0] REG_SPEED    = 3'd2;
  localparam logic [2:0] REG_NEAR     = 3'd3;
  localparam logic [2:0] REG_FAR      = 3'd4;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ABS, OP_SQA, OP_SQB, OP_SQSUM, OP_ROOT_STEP,
    OP_ROOT2_INIT, OP_DUR, OP_COUNT, OP_DIV_INIT, OP_DIV_STEP,
    OP_M_DE, OP_M_W1, OP_M_W2, OP_M_DD, OP_M_W3, OP_M_T1, OP_M_T2,
    OP_F, OP_M_X, OP_M_Y, OP_Y_FIN, OP_PIN, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_latch;
    logic go;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bpt_dp.sv =====
// Datapath: configuration, trajectory state, shared multiplier, root and divider steps.
`include "bezier_pan_trajectory_defines.svh"

module bpt_dp import bpt_pkg::*; #(
  parameter int unsigned EDGE_OFFSET = EdgeOffsetDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [71:0] in_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [71:0] out_data
);

  function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
    if (v > 54'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -54'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Configuration registers.
  logic signed [31:0] target_x, target_y;
  logic [15:0]        speed;
  logic signed [15:0] near_fraction, far_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x      <= '0;
      target_y      <= '0;
      speed         <= 16'd4096;
      near_fraction <= 16'sd4096;
      far_fraction  <= 16'sd12288;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_X: target_x      <= cfg_data;
        REG_TARGET_Y: target_y      <= cfg_data;
        REG_SPEED:    speed         <= cfg_data[15:0];
        REG_NEAR:     near_fraction <= cfg_data[15:0];
        REG_FAR:      far_fraction  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Target with the edge offset applied.
  logic signed [32:0] tx_sum, ty_sum;
  logic signed [31:0] tx, ty;
  assign tx_sum = 33'(target_x) + 33'(EDGE_OFFSET);
  assign ty_sum = 33'(target_y) + 33'(EDGE_OFFSET);
  assign tx = sat32(54'(tx_sum));
  assign ty = sat32(54'(ty_sum));

  // Tick state and working registers.
  logic signed [31:0] cur_x, cur_y, start_x, start_y;
  logic               start_latched, done_flag, shift_s;
  logic [27:0]        progress_count, duration, rem;
  logic [30:0]        a_mag, b_mag;
  logic [62:0]        acc;
  logic [63:0]        rv, rr, rbit;
  logic [15:0]        quo;
  logic [16:0]        de, w1, w2, w3;
  logic signed [33:0] t1;
  logic signed [26:0] f16;
  logic signed [31:0] res_x, res_y;
  logic signed [67:0] prod;

  // Absolute differences to the target.
  logic signed [32:0] dx, dy;
  logic [31:0]        ax, ay;
  assign dx = 33'(tx) - 33'(cur_x);
  assign dy = 33'(ty) - 33'(cur_y);
  assign ax = dx[32] ? 32'(-dx) : dx[31:0];
  assign ay = dy[32] ? 32'(-dy) : dy[31:0];

  // One restoring square-root iteration.
  logic [63:0] root_trial;
  assign root_trial = rr + rbit;

  // One restoring division step.
  logic [28:0] rem2;
  assign rem2 = {rem, 1'b0};

  // Bezier weights from the quotient.
  logic [16:0] d_val, e_val;
  assign d_val = {1'b0, quo};
  assign e_val = 17'h10000 - d_val;

  logic [28:0] cnt_sum;
  assign cnt_sum = {1'b0, progress_count} + 29'(speed[15:4]);

  logic signed [39:0] fsum;
  assign fsum = 40'(t1) * 40'sd3 + 40'($signed(prod[33:0])) * 40'sd3
              + 40'({1'b0, w3, 14'd0});

  logic signed [53:0] pos_sum;
  assign pos_sum = 54'(start_x) + 54'($signed(prod[67:16]));

  // Shared multiplier operand selection.
  logic signed [33:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_SQA:  begin ma = 34'({1'b0, a_mag}); mb = 34'({1'b0, a_mag}); end
      OP_SQB:  begin ma = 34'({1'b0, b_mag}); mb = 34'({1'b0, b_mag}); end
      OP_M_DE: begin ma = 34'({1'b0, d_val}); mb = 34'({1'b0, e_val}); end
      OP_M_W1: begin ma = 34'({1'b0, prod[32:16]}); mb = 34'({1'b0, e_val}); end
      OP_M_W2: begin ma = 34'({1'b0, de}); mb = 34'({1'b0, d_val}); end
      OP_M_DD: begin ma = 34'({1'b0, d_val}); mb = 34'({1'b0, d_val}); end
      OP_M_W3: begin ma = 34'({1'b0, prod[32:16]}); mb = 34'({1'b0, d_val}); end
      OP_M_T1: begin ma = 34'(near_fraction); mb = 34'({1'b0, w1}); end
      OP_M_T2: begin ma = 34'(far_fraction); mb = 34'({1'b0, w2}); end
      OP_M_X:  begin ma = 34'(33'(tx) - 33'(start_x)); mb = 34'(f16); end
      OP_M_Y:  begin ma = 34'(33'(ty) - 33'(start_y)); mb = 34'(f16); end
      default: ;
    endcase
  end

  // Operation execution.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_latched  <= 1'b0;
      done_flag      <= 1'b0;
      progress_count <= '0;
      duration       <= '0;
      start_x        <= '0;
      start_y        <= '0;
    end else begin
      prod <= ma * mb;
      case (cmd.op)
        OP_LOAD: begin
          cur_x   <= in_data[32:1];
          cur_y   <= in_data[64:33];
          if (in_data[0]) begin
            start_latched <= 1'b0;
          end
        end
        OP_ABS: begin
          start_x        <= cur_x;
          start_y        <= cur_y;
          start_latched  <= 1'b1;
          progress_count <= '0;
          shift_s        <= ax[31] | ay[31];
          a_mag          <= (ax[31] | ay[31]) ? ax[31:1] : ax[30:0];
          b_mag          <= (ax[31] | ay[31]) ? ay[31:1] : ay[30:0];
        end
        OP_SQB: acc <= prod[62:0];
        OP_SQSUM: begin
          rv   <= {1'b0, acc} + {1'b0, prod[62:0]};
          rr   <= '0;
          rbit <= 64'h4000_0000_0000_0000;
        end
        OP_ROOT_STEP: begin
          if (rv >= root_trial) begin
            rv <= rv - root_trial;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
        end
        OP_ROOT2_INIT: begin
          rv   <= ({32'd0, rr[31:0]} << shift_s) << 13;
          rr   <= '0;
          rbit <= 64'h4000_0000_0000_0000;
        end
        OP_DUR: duration <= (rr > 64'(CntMax)) ? CntMax : rr[27:0];
        OP_COUNT: progress_count <= cnt_sum[28] ? CntMax : cnt_sum[27:0];
        OP_DIV_INIT: begin
          rem <= progress_count;
          quo <= '0;
        end
        OP_DIV_STEP: begin
          if (rem2 >= {1'b0, duration}) begin
            rem <= 28'(rem2 - {1'b0, duration});
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= rem2[27:0];
            quo <= {quo[14:0], 1'b0};
          end
        end
        OP_M_W1: de <= prod[32:16];
        OP_M_W2: w1 <= prod[32:16];
        OP_M_DD: w2 <= prod[32:16];
        OP_M_T1: w3 <= prod[32:16];
        OP_M_T2: t1 <= prod[33:0];
        OP_F:    f16 <= {fsum[39], fsum[39:14]};
        OP_M_Y:  res_x <= sat32(pos_sum);
        OP_Y_FIN: res_y <= sat32(54'(start_y) + 54'($signed(prod[67:16])));
        OP_PIN: begin
          res_x     <= tx;
          res_y     <= ty;
          done_flag <= 1'b1;
        end
        OP_EMIT: out_data <= {7'd0, done_flag, res_y, res_x};
        default: ;
      endcase
    end
  end

  assign stat.need_latch = ~start_latched;
  assign stat.go         = ~done_flag && (progress_count < duration);

  `BPT_ASSERT_NXT(a_done_sticky, done_flag, done_flag)
  `BPT_ASSERT_NXT(a_abs_latches, cmd.op == OP_ABS, start_latched)

endmodule

// ===== hw/rtl/bpt_ctrl.sv =====
// Controller: sequences the datapath operations for one tick and owns the handshakes.
`include "bezier_pan_trajectory_defines.svh"

module bpt_ctrl import bpt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_ABS, ST_SQA, ST_SQB, ST_SQSUM, ST_ROOT1, ST_ROOT2I,
    ST_ROOT2, ST_DUR, ST_COUNT, ST_DECIDE, ST_DIVI, ST_DIV, ST_MUL, ST_EMIT
  } state_t;

  state_t     state;
  logic [4:0] step;
  logic       emit_ok;

  assign in_ready = (state == ST_IDLE);
  assign emit_ok  = ~out_valid | out_ready;

  // Operation decode from state and step.
  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      ST_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_ABS:    cmd.op = OP_ABS;
      ST_SQA:    cmd.op = OP_SQA;
      ST_SQB:    cmd.op = OP_SQB;
      ST_SQSUM:  cmd.op = OP_SQSUM;
      ST_ROOT1:  cmd.op = OP_ROOT_STEP;
      ST_ROOT2:  cmd.op = OP_ROOT_STEP;
      ST_ROOT2I: cmd.op = OP_ROOT2_INIT;
      ST_DUR:    cmd.op = OP_DUR;
      ST_COUNT:  cmd.op = OP_COUNT;
      ST_DECIDE: cmd.op = stat.go ? OP_NONE : OP_PIN;
      ST_DIVI:   cmd.op = OP_DIV_INIT;
      ST_DIV:    cmd.op = OP_DIV_STEP;
      ST_MUL: begin
        unique case (step)
          5'd0:    cmd.op = OP_M_DE;
          5'd1:    cmd.op = OP_M_W1;
          5'd2:    cmd.op = OP_M_W2;
          5'd3:    cmd.op = OP_M_DD;
          5'd4:    cmd.op = OP_M_W3;
          5'd5:    cmd.op = OP_M_T1;
          5'd6:    cmd.op = OP_M_T2;
          5'd7:    cmd.op = OP_F;
          5'd8:    cmd.op = OP_M_X;
          5'd9:    cmd.op = OP_M_Y;
          5'd10:   cmd.op = OP_Y_FIN;
          default: cmd.op = OP_NONE;
        endcase
      end
      ST_EMIT:   cmd.op = emit_ok ? OP_EMIT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // State, step counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:   if (in_valid) begin
          state <= ST_CHECK;
        end
        ST_CHECK:  state <= stat.need_latch ? ST_ABS : ST_COUNT;
        ST_ABS:    state <= ST_SQA;
        ST_SQA:    state <= ST_SQB;
        ST_SQB:    state <= ST_SQSUM;
        ST_SQSUM:  begin
          state <= ST_ROOT1;
          step  <= '0;
        end
        ST_ROOT1:  begin
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= ST_ROOT2I;
          end
        end
        ST_ROOT2I: begin
          state <= ST_ROOT2;
          step  <= '0;
        end
        ST_ROOT2:  begin
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= ST_DUR;
          end
        end
        ST_DUR:    state <= ST_COUNT;
        ST_COUNT:  state <= ST_DECIDE;
        ST_DECIDE: begin
          state <= stat.go ? ST_DIVI : ST_EMIT;
        end
        ST_DIVI:   begin
          state <= ST_DIV;
          step  <= '0;
        end
        ST_DIV:    begin
          step <= step + 5'd1;
          if (step == 5'd15) begin
            state <= ST_MUL;
            step  <= '0;
          end
        end
        ST_MUL:    begin
          step <= step + 5'd1;
          if (step == 5'd10) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT:   if (emit_ok) begin
          state <= ST_IDLE;
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  `BPT_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state == ST_CHECK)
  `BPT_ASSERT_IMP(a_div_step_range, state == ST_DIV, step < 5'd16)
  `BPT_ASSERT_NXT(a_emit_waits, state == ST_EMIT && !emit_ok, state == ST_EMIT)

endmodule

// ===== hw/rtl/bezier_pan_trajectory.sv =====
// Bezier pan trajectory: one request per tick yields the next view point on the curve.
// Each request (one tick) produces exactly one result. A tick that latches a new start point
// first runs two 32-step square-root passes for the distance and the duration; every tick
// still on its way then runs a 16-step divider for the curve parameter and an 11-step
// sequence on one shared multiplier. A tick that ends on the target skips divider and
// multiplier. The block then returns to idle before the next request, and a result still
// waiting in the output register holds the next one back until it is read. A new request
// is taken once the previous result has been placed in the output register, even if it
// is not yet read. Configuration writes are always ready and must only be issued while no
// tick is in work.
module bezier_pan_trajectory import bpt_pkg::*; #(
  parameter int unsigned EDGE_OFFSET = EdgeOffsetDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,    // restart, current_x[32:1], current_y[64:33], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,    // out_x[31:0], out_y[63:32], finished[64], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  bpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  bpt_dp #(
    .EDGE_OFFSET (EDGE_OFFSET)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the bezier pan trajectory block.
`timescale 1ns / 1ps

module tb_top;
  import bpt_pkg::*;

  localparam int unsigned EDGE = EdgeOffsetDefault;
  localparam logic [63:0] COUNT_LIMIT = 64'h0FFF_FFFF;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        finished;
  } view_point_t;

  // One row of the directed table; the expected point is only used when known_out is set.
  typedef struct {
    logic        restart;
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic        known_out;
    view_point_t want;
  } tick_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;    // restart, current_x, current_y, zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;    // out_x, out_y, finished, zero fill
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Shadow copies of the registers and trajectory state.
  longint      tgt_x, tgt_y, spd, frac_b, frac_c;
  longint      org_x, org_y;
  logic        org_valid;
  logic [63:0] progress, span;
  logic        arrived;

  view_point_t expected_points[$];
  int          errors;
  int          ticks_sent;
  int          points_seen;
  int          finished_seen;
  bit          quiet_sink;
  bit          quiet_source;

  bezier_pan_trajectory #(.EDGE_OFFSET(EDGE)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit well above the slowest legal run.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advance the trajectory by one tick and return the new view point.
  function automatic view_point_t advance_view(logic restart, logic [31:0] cx_raw,
                                               logic [31:0] cy_raw);
    longint      cx, cy, tx, ty, w1, w2, w3, f, f16;
    logic [63:0] a, b, flight_len, dur, d, e, de;
    int          s;
    view_point_t p;
    cx = longint'($signed(cx_raw));
    cy = longint'($signed(cy_raw));
    tx = clamp32(tgt_x + longint'(EDGE));
    ty = clamp32(tgt_y + longint'(EDGE));
    if (restart) org_valid = 1'b0;
    // Latch a new start point and size the flight from its distance.
    if (!org_valid) begin
      org_x = cx;
      org_y = cy;
      org_valid = 1'b1;
      progress = 0;
      a = (tx >= cx) ? 64'(tx - cx) : 64'(cx - tx);
      b = (ty >= cy) ? 64'(ty - cy) : 64'(cy - ty);
      s = (a >= 64'h8000_0000 || b >= 64'h8000_0000) ? 1 : 0;
      a = a >> s;
      b = b >> s;
      flight_len = root_floor(a * a + b * b) << s;
      dur = root_floor(flight_len << 13);
      span = (dur > COUNT_LIMIT) ? COUNT_LIMIT : dur;
    end
    progress = progress + 64'(spd >>> 4);
    if (progress > COUNT_LIMIT) progress = COUNT_LIMIT;
    if (!arrived && progress < span) begin
      d = (progress << 16) / span;
      e = 64'd65536 - d;
      de = (d * e) >> 16;
      w1 = longint'((de * e) >> 16);
      w2 = longint'((de * d) >> 16);
      w3 = longint'((((d * d) >> 16) * d) >> 16);
      f = 3 * frac_b * w1 + 3 * frac_c * w2 + w3 * 16384;
      f16 = f >>> 14;
      p.x = 32'(clamp32(org_x + (((tx - org_x) * f16) >>> 16)));
      p.y = 32'(clamp32(org_y + (((ty - org_y) * f16) >>> 16)));
    end else begin
      p.x = 32'(tx);
      p.y = 32'(ty);
      arrived = 1'b1;
    end
    p.finished = arrived;
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s at point %0d: got %h expected %h", what, points_seen, got, want);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result sink with random back-pressure.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      stall_left <= pick_gap(quiet_sink);
    end
  end

  // Compare each returned point with the oldest prediction.
  always @(posedge clk) begin
    view_point_t want;
    if (!rst && m_tvalid && m_tready) begin
      points_seen++;
      if (m_tdata[64]) finished_seen++;
      if (expected_points.size() == 0) begin
        errors++;
        $display("UNEXPECTED point %0d: %h", points_seen, m_tdata[64:0]);
      end else begin
        want = expected_points.pop_front();
        if (m_tdata[31:0] !== want.x) report_mismatch("out_x", m_tdata[31:0], want.x);
        if (m_tdata[63:32] !== want.y) report_mismatch("out_y", m_tdata[63:32], want.y);
        if (m_tdata[64] !== want.finished)
          report_mismatch("finished", 32'(m_tdata[64]), 32'(want.finished));
        if (m_tdata[71:65] !== 7'd0) report_mismatch("fill", 32'(m_tdata[71:65]), 32'd0);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TARGET_X: tgt_x = longint'($signed(value));
      REG_TARGET_Y: tgt_y = longint'($signed(value));
      REG_SPEED:    spd = longint'(value[15:0]);
      REG_NEAR:     frac_b = longint'($signed(value[15:0]));
      REG_FAR:      frac_c = longint'($signed(value[15:0]));
      default: ;
    endcase
  endtask

  // Present one tick request; valid stays high across back-to-back requests.
  task automatic send_tick(logic restart, logic [31:0] cx, logic [31:0] cy,
                           logic known_out, view_point_t want);
    int gap;
    view_point_t p;
    gap = pick_gap(quiet_source);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, cy, cx, restart};
    do @(posedge clk); while (!s_tready);
    p = advance_view(restart, cx, cy);
    if (known_out && p !== want) begin
      errors++;
      $display("TABLE row %0d disagrees with predictor", ticks_sent);
    end
    expected_points.push_back(p);
    ticks_sent++;
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    if (s_tvalid) s_tvalid <= 1'b0;
    while (expected_points.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_points.size() != 0) begin
      $display("*** FAILED ***");
      $finish;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic random_ticks(int count, int restart_pct);
    logic [31:0] cx, cy;
    view_point_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        cx = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        cy = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
        cx = $urandom;
        cy = $urandom;
      end
      send_tick(($urandom_range(99) < restart_pct), cx, cy, 1'b0, none);
    end
  endtask

  // Directed ticks: with speed zero and a far target a restart outputs its start point.
  tick_row_t rows[] = '{
    '{1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}},
    '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
    '{1'b1, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 32'h8000_0000, 1'b0}},
    '{1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0}},
    '{1'b0, 32'h1234_5678, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0}},
    '{1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0}},
    '{1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0}},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{1'b1, 32'h0000_1000, 32'hFFFF_F000, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{1'b0, 32'h8000_0000, 32'h8000_0000, 1'b0, '{32'h0, 32'h0, 1'b0}}
  };

  initial begin
    view_point_t pinned;
    errors = 0;
    ticks_sent = 0;
    points_seen = 0;
    finished_seen = 0;
    quiet_sink = 1'b0;
    quiet_source = 1'b0;
    tgt_x = 0; tgt_y = 0; spd = 4096; frac_b = 4096; frac_c = 12288;
    org_x = 0; org_y = 0; org_valid = 1'b0;
    progress = 0; span = 0; arrived = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TARGET_X;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Far target and frozen progress for the directed table.
    write_reg(REG_TARGET_X, 32'h4000_0000);
    write_reg(REG_TARGET_Y, 32'hC000_0000);
    write_reg(REG_SPEED, 32'd0);
    write_reg(REG_NEAR, 32'h0000_7FFF);
    write_reg(REG_FAR, 32'hFFFF_8000);
    foreach (rows[i]) send_tick(rows[i].restart, rows[i].cur_x, rows[i].cur_y,
                                rows[i].known_out, rows[i].want);
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      quiet_sink = (ph == 2);
      quiet_source = (ph == 2 || ph == 5);
      case (ph)
        0: begin
          write_reg(REG_SPEED, 32'd65535);
          write_reg(REG_NEAR, 32'd4096);
          write_reg(REG_FAR, 32'd12288);
        end
        1: begin
          write_reg(REG_TARGET_X, 32'h7FFF_FFFF);
          write_reg(REG_TARGET_Y, 32'h8000_0000);
          write_reg(REG_NEAR, 32'hFFFF_8000);
          write_reg(REG_FAR, 32'h0000_7FFF);
        end
        2: begin
          write_reg(REG_TARGET_X, 32'h8000_0000);
          write_reg(REG_SPEED, 32'd16);
        end
        3: begin
          write_reg(REG_NEAR, 32'd0);
          write_reg(REG_FAR, 32'd16384);
          write_reg(REG_SPEED, 32'($urandom_range(65535)));
        end
        default: begin
          write_reg(REG_TARGET_X, $urandom);
          write_reg(REG_TARGET_Y, $urandom);
          write_reg(REG_SPEED, 32'($urandom_range(65535)));
          write_reg(REG_NEAR, 32'($urandom_range(65535)));
          write_reg(REG_FAR, 32'($urandom_range(65535)));
        end
      endcase
      random_ticks(110, (ph == 3) ? 3 : 25);
      drain();
    end

    // Zero distance: the first tick lands on the target and the flag sticks for good.
    quiet_sink = 1'b0;
    quiet_source = 1'b0;
    write_reg(REG_TARGET_X, 32'h0012_3000);
    write_reg(REG_TARGET_Y, 32'hFFED_C000);
    write_reg(REG_SPEED, 32'd4096);
    pinned = '{32'h0012_3000, 32'hFFED_C000, 1'b1};
    send_tick(1'b1, 32'h0012_3000, 32'hFFED_C000, 1'b1, pinned);
    send_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, pinned);
    random_ticks(40, 30);
    drain();

    $display("Covered %0d ticks and %0d returned points, %0d of them with the flag set.",
             ticks_sent, points_seen, finished_seen);
    $display("Register settings swept fraction, speed and target extremes.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
